@@ rtl/core/laags_pkg.sv @@
// Shared types, widths and helpers for the local alignment affine gap scorer.
// Used by the cell, the collector and the top level; depends on nothing.
`default_nettype none

package laags_pkg;

  localparam int QUERY_MAX = 64;
  localparam int IDX_W     = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int LEN_W     = $clog2(QUERY_MAX + 1);

  localparam int SYM_W   = 8;
  localparam int SCORE_W = 15;
  localparam int GAP_W   = 16;
  localparam int CALC_W  = 18;
  localparam int PEN_W   = 8;
  localparam int MIS_W   = 9;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic signed [CALC_W-1:0] SCORE_CAP = CALC_W'(32767);

  localparam logic [PEN_W-1:0] MATCH_RST    = 8'd10;
  localparam logic [MIS_W-1:0] MISMATCH_RST = 9'h1F1;
  localparam logic [PEN_W-1:0] GAP_OPEN_RST = 8'd40;
  localparam logic [PEN_W-1:0] GAP_EXT_RST  = 8'd7;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_STREAM = 1'b1;

  typedef enum logic [1:0] {
    REG_MATCH      = 2'd0,
    REG_MISMATCH   = 2'd1,
    REG_GAP_OPEN   = 2'd2,
    REG_GAP_EXTEND = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PEN_W-1:0] match;
    logic [MIS_W-1:0] mismatch;
    logic [PEN_W-1:0] open;
    logic [PEN_W-1:0] extend;
  } pen_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
  } qload_t;

  // One database column travelling down the chain.
  typedef struct packed {
    logic                    valid;
    logic [SYM_W-1:0]        sym;
    logic                    first_col;
    logic                    last;
    logic [LEN_W-1:0]        len;
    logic [SCORE_W-1:0]      up;
    logic signed [GAP_W-1:0] vgap;
    logic [SCORE_W-1:0]      diag;
    logic [SCORE_W-1:0]      best;
    logic                    sat;
  } wave_t;

  function automatic logic signed [CALC_W-1:0] smax(
    input logic signed [CALC_W-1:0] a,
    input logic signed [CALC_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/laags_cell.sv @@
// One query row of the scoring chain: holds the row's symbol, last cell score
// and row gap score. Depends on laags_pkg.
`default_nettype none

module laags_cell
  import laags_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire pen_t             pen,
  input  wire qload_t           qload,
  input  wire wave_t            wave_in,
  output wave_t                 wave_out
);

  logic [SYM_W-1:0]        q_sym;
  logic [SCORE_W-1:0]      h_reg;
  logic signed [GAP_W-1:0] f_reg;

  logic                     active;
  logic signed [CALC_W-1:0] open_s, ext_s, oe_s, sub_s;
  logic signed [CALC_W-1:0] prev_h, prev_f, v_s, f_s, h_s;
  logic                     clamp;
  wave_t                    wave_next;

  assign active = wave_in.valid && (LEN_W'(cell_idx) < wave_in.len);

  always_comb begin
    open_s = $signed({{(CALC_W-PEN_W){1'b0}}, pen.open});
    ext_s  = $signed({{(CALC_W-PEN_W){1'b0}}, pen.extend});
    oe_s   = open_s + ext_s;
    sub_s  = (q_sym == wave_in.sym) ? $signed({{(CALC_W-PEN_W){1'b0}}, pen.match})
                                    : $signed({{(CALC_W-MIS_W){pen.mismatch[MIS_W-1]}},
                                               pen.mismatch});
    // A first column sees the cleared row state.
    prev_h = wave_in.first_col ? '0 : $signed({{(CALC_W-SCORE_W){1'b0}}, h_reg});
    prev_f = wave_in.first_col ? -open_s
                               : $signed({{(CALC_W-GAP_W){f_reg[GAP_W-1]}}, f_reg});
    v_s = smax($signed({{(CALC_W-GAP_W){wave_in.vgap[GAP_W-1]}}, wave_in.vgap}) - ext_s,
               $signed({{(CALC_W-SCORE_W){1'b0}}, wave_in.up}) - oe_s);
    f_s = smax(prev_f - ext_s, prev_h - oe_s);
    h_s = smax($signed({{(CALC_W-SCORE_W){1'b0}}, wave_in.diag}) + sub_s, '0);
    h_s = smax(h_s, v_s);
    h_s = smax(h_s, f_s);
    clamp = (h_s > SCORE_CAP);
    if (clamp) begin
      h_s = SCORE_CAP;
    end

    wave_next = wave_in;
    if (active) begin
      wave_next.up   = h_s[SCORE_W-1:0];
      wave_next.vgap = v_s[GAP_W-1:0];
      wave_next.diag = prev_h[SCORE_W-1:0];
      wave_next.best = (h_s[SCORE_W-1:0] > wave_in.best) ? h_s[SCORE_W-1:0] : wave_in.best;
      wave_next.sat  = wave_in.sat | clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (qload.en && (qload.idx == cell_idx)) begin
      q_sym <= qload.sym;
    end
    if (active) begin
      h_reg <= h_s[SCORE_W-1:0];
      f_reg <= f_s[GAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_next.valid;
    end
    wave_out.sym       <= wave_next.sym;
    wave_out.first_col <= wave_next.first_col;
    wave_out.last      <= wave_next.last;
    wave_out.len       <= wave_next.len;
    wave_out.up        <= wave_next.up;
    wave_out.vgap      <= wave_next.vgap;
    wave_out.diag      <= wave_next.diag;
    wave_out.best      <= wave_next.best;
    wave_out.sat       <= wave_next.sat;
  end

endmodule

`default_nettype wire

@@ rtl/core/laags_collect.sv @@
// Tail of the chain: folds column maxima into the alignment maximum and
// issues the result on a last column. Depends on laags_pkg.
`default_nettype none

module laags_collect
  import laags_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire wave_t        wave_in,
  output logic              done,
  output logic [SCORE_W-1:0] score,
  output logic              saturated
);

  logic [SCORE_W-1:0] best_acc, best_next;
  logic               sat_acc, sat_next;

  always_comb begin
    if (wave_in.first_col) begin
      best_next = wave_in.best;
      sat_next  = wave_in.sat;
    end else begin
      best_next = (wave_in.best > best_acc) ? wave_in.best : best_acc;
      sat_next  = sat_acc | wave_in.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wave_in.valid && wave_in.last;
    end
    if (wave_in.valid) begin
      best_acc  <= best_next;
      sat_acc   <= sat_next;
      score     <= best_next;
      saturated <= sat_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/local_alignment_affine_gap_scorer_top.sv @@
// Local alignment scorer, affine gaps: registers, input control and the chain.
// Depends on laags_pkg, laags_cell and laags_collect.
// A last database item's result is registered in the launch stage, in every
// cell of the chain and in the collector. Throughput: one item per cycle,
// loads and database symbols alike; busy stays low.
// Reset: synchronous, active high; registers return to their defaults, the
// query is empty and the chain is drained. The receiver cannot stall results.
`default_nettype none

module local_alignment_affine_gap_scorer_top
  import laags_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // item port
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              action,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic              last,
  // result port
  output logic                   done,
  output logic [SCORE_W-1:0]     score,
  output logic                   saturated,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  pen_t             pen;
  logic             reg_we;
  reg_idx_t         reg_sel;

  logic             accept;
  logic             in_alignment;
  logic             start_new_query;
  logic [LEN_W-1:0] query_length;
  logic [LEN_W-1:0] load_base;
  qload_t           qload;
  wave_t            wave0;
  wave_t            chain [QUERY_MAX+1];

  // Every item can enter the chain right away: no back-pressure.
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // ---------------- register port ----------------
  assign reg_we  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen.match    <= MATCH_RST;
      pen.mismatch <= MISMATCH_RST;
      pen.open     <= GAP_OPEN_RST;
      pen.extend   <= GAP_EXT_RST;
    end else if (reg_we) begin
      unique case (reg_sel)
        REG_MATCH:      pen.match    <= pwdata[PEN_W-1:0];
        REG_MISMATCH:   pen.mismatch <= pwdata[MIS_W-1:0];
        REG_GAP_OPEN:   pen.open     <= pwdata[PEN_W-1:0];
        REG_GAP_EXTEND: pen.extend   <= pwdata[PEN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MATCH:      prdata = {{(DATA_W-PEN_W){1'b0}}, pen.match};
      REG_MISMATCH:   prdata = {{(DATA_W-MIS_W){pen.mismatch[MIS_W-1]}}, pen.mismatch};
      REG_GAP_OPEN:   prdata = {{(DATA_W-PEN_W){1'b0}}, pen.open};
      REG_GAP_EXTEND: prdata = {{(DATA_W-PEN_W){1'b0}}, pen.extend};
      default:        prdata = '0;
    endcase
  end

  // ---------------- input control ----------------
  // A load after a result restarts the query at row zero.
  assign load_base = start_new_query ? '0 : query_length;

  always_comb begin
    qload.en  = accept && (action == ACT_LOAD) && (load_base < LEN_W'(QUERY_MAX));
    qload.idx = load_base[IDX_W-1:0];
    qload.sym = symbol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_alignment    <= 1'b0;
      start_new_query <= 1'b1;
      query_length    <= '0;
    end else if (accept) begin
      if (action == ACT_LOAD) begin
        // Drop any alignment in progress; append unless the query is full.
        in_alignment    <= 1'b0;
        start_new_query <= 1'b0;
        query_length    <= qload.en ? load_base + LEN_W'(1) : load_base;
      end else begin
        in_alignment <= !last;
        if (last) begin
          start_new_query <= 1'b1;
        end
      end
    end
  end

  // Launch a column: the first column of an alignment carries the clear
  // request down the chain, together with the query length it was issued
  // against, so later loads cannot disturb it.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave0.valid <= 1'b0;
    end else begin
      wave0.valid <= accept && (action == ACT_STREAM);
    end
    wave0.sym       <= symbol;
    wave0.first_col <= !in_alignment;
    wave0.last      <= last;
    wave0.len       <= query_length;
    wave0.up        <= '0;
    wave0.vgap      <= -$signed({{(GAP_W-PEN_W){1'b0}}, pen.open});
    wave0.diag      <= '0;
    wave0.best      <= '0;
    wave0.sat       <= 1'b0;
  end

  // ---------------- cell chain ----------------
  assign chain[0] = wave0;

  for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
    laags_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .pen      (pen),
      .qload    (qload),
      .wave_in  (chain[g]),
      .wave_out (chain[g+1])
    );
  end

  laags_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .wave_in   (chain[QUERY_MAX]),
    .done      (done),
    .score     (score),
    .saturated (saturated)
  );

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    query_length <= LEN_W'(QUERY_MAX))
    else $error("query length beyond capacity");

  a_new_query: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_LOAD) && start_new_query) |=> (query_length == LEN_W'(1)))
    else $error("fresh query did not restart at one symbol");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_STREAM) && last) |=> (!in_alignment && start_new_query))
    else $error("last column did not close the alignment");

  a_first_after_load: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_LOAD)) |=> !in_alignment)
    else $error("load left an alignment open");
`endif

endmodule

`default_nettype wire
